// ===== rtl/bmhq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_pkg: shared definitions for the binary max-heap queue
// Key and status widths, action and status codes, controller state type.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int unsigned HEAP_DEPTH_DEF = 64;
  localparam int unsigned KEY_W          = 32;
  localparam int unsigned STATUS_W       = 2;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_RD_TOP,
    ST_RD_LAST,
    ST_DN_LEFT,
    ST_DN_RIGHT,
    ST_PLACE,
    ST_DONE
  } bmhq_state_t;

  // Signed compare of two key patterns: a < b.
  function automatic logic key_less(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

// ===== rtl/bmhq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_if: item channels of the binary max-heap queue
// Valid/ready channels for the request items and the result items.
// ----------------------------------------------------------------------------
interface bmhq_in_if;
  import bmhq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [KEY_W-1:0] key_in;

  modport source (output valid, output action, output key_in, input ready);
  modport sink   (input valid, input action, input key_in, output ready);
endinterface

interface bmhq_out_if;
  import bmhq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] key_out;
  logic [STATUS_W-1:0]     status;

  modport source (output valid, output key_out, output status, input ready);
  modport sink   (input valid, input key_out, input status, output ready);
endinterface

// ===== rtl/binary_max_heap_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_queue_unit: binary max-heap priority queue
// Holds up to HEAP_DEPTH signed keys in one synchronous RAM; insert sifts up,
// remove returns the root and sifts the last entry down.
// ----------------------------------------------------------------------------
// Steps, accept to result valid: insert reads one parent per level in ST_UP;
//   remove reads the root and the last entry, then per level down reads the
//   left and right child in turn (both child reads share the RAM read port);
//   full or empty goes straight to ST_DONE. One item at a time; the next
//   item is taken even while the last result still waits at the output.
// Reset: synchronous, active low; clears the count and output valid, not RAM.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_unit #(
  parameter int unsigned HEAP_DEPTH = bmhq_pkg::HEAP_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bmhq_in_if.sink     in_ch,
  bmhq_out_if.source  out_ch
);
  import bmhq_pkg::*;

  localparam int unsigned ADDR_W  = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W   = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned CHILD_W = ADDR_W + 1;
  localparam int unsigned CMP_W   = ADDR_W + 2;

  // Heap RAM: one write and one registered read per cycle.
  logic [KEY_W-1:0]  heap_mem [HEAP_DEPTH];
  logic [KEY_W-1:0]  mem_rd_r;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [KEY_W-1:0]  wr_data;
  logic [ADDR_W-1:0] rd_addr;

  bmhq_state_t        state_r,  state_nxt;
  logic [CNT_W-1:0]   count_r,  count_nxt;
  logic [ADDR_W-1:0]  pos_r,    pos_nxt;    // hole the moving key sits over
  logic [CHILD_W-1:0] child_r,  child_nxt;  // left child of the hole
  logic [KEY_W-1:0]   key_r,    key_nxt;    // moving key (new key or last)
  logic [KEY_W-1:0]   top_r,    top_nxt;    // key returned with the result
  logic [KEY_W-1:0]   left_r,   left_nxt;
  status_t            status_r, status_nxt;

  logic               out_valid_r;
  logic [KEY_W-1:0]   key_out_r;
  status_t            status_out_r;
  logic               load_out;
  logic               out_free;
  logic               in_ready;

  // Sift helpers
  logic [ADDR_W-1:0]  parent_idx;
  logic [ADDR_W-1:0]  grand_idx;
  logic [CMP_W-1:0]   count_ext;
  logic [CMP_W-1:0]   right_ext;
  logic               right_ok;
  logic               take_right;
  logic [KEY_W-1:0]   big_key;
  logic [ADDR_W-1:0]  big_idx;
  logic [CHILD_W-1:0] next_child;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign parent_idx = (pos_r - ADDR_W'(1)) >> 1;
  assign grand_idx  = (parent_idx - ADDR_W'(1)) >> 1;
  assign count_ext  = CMP_W'(count_r);
  assign right_ext  = CMP_W'(child_r) + CMP_W'(1);
  assign right_ok   = right_ext < count_ext;
  // Equal children: keep the left one.
  assign take_right = right_ok && key_less(left_r, mem_rd_r);
  assign big_key    = take_right ? mem_rd_r : left_r;
  assign big_idx    = take_right ? right_ext[ADDR_W-1:0] : child_r[ADDR_W-1:0];
  assign next_child = {big_idx, 1'b1};

  // Reads and writes never hit the same entry in one cycle: the read always
  // targets an ancestor or descendant of the entry being written.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    mem_rd_r <= heap_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    child_r  <= child_nxt;
    key_r    <= key_nxt;
    top_r    <= top_nxt;
    left_r   <= left_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    child_nxt  = child_r;
    key_nxt    = key_r;
    top_nxt    = top_r;
    left_nxt   = left_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    wr_addr    = pos_r;
    wr_data    = key_r;
    rd_addr    = parent_idx;
    in_ready   = 1'b0;
    load_out   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          status_nxt = STAT_DONE;
          top_nxt    = '0;
          if (in_ch.action == ACT_INSERT) begin
            if (count_r == CNT_W'(HEAP_DEPTH)) begin
              // Drop the key, report full.
              status_nxt = STAT_FULL;
              state_nxt  = ST_DONE;
            end else begin
              count_nxt = count_r + CNT_W'(1);
              pos_nxt   = count_r[ADDR_W-1:0];
              key_nxt   = in_ch.key_in;
              if (count_r == '0) begin
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data   = in_ch.key_in;
                state_nxt = ST_DONE;
              end else begin
                rd_addr   = (count_r[ADDR_W-1:0] - ADDR_W'(1)) >> 1;
                state_nxt = ST_UP;
              end
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = STAT_EMPTY;
              state_nxt  = ST_DONE;
            end else begin
              count_nxt = count_r - CNT_W'(1);
              pos_nxt   = '0;
              rd_addr   = '0;
              state_nxt = ST_RD_TOP;
            end
          end
        end
      end

      ST_UP: begin
        // Parent key is in mem_rd_r; stop at a parent that is not smaller.
        if (key_less(mem_rd_r, key_r)) begin
          wr_en   = 1'b1;
          wr_addr = pos_r;
          wr_data = mem_rd_r;
          pos_nxt = parent_idx;
          if (parent_idx == '0) begin
            state_nxt = ST_PLACE;
          end else begin
            rd_addr = grand_idx;
          end
        end else begin
          wr_en     = 1'b1;
          wr_addr   = pos_r;
          wr_data   = key_r;
          state_nxt = ST_DONE;
        end
      end

      ST_RD_TOP: begin
        top_nxt   = mem_rd_r;
        rd_addr   = count_r[ADDR_W-1:0];
        child_nxt = CHILD_W'(1);
        state_nxt = ST_RD_LAST;
      end

      ST_RD_LAST: begin
        key_nxt = mem_rd_r;
        if (CMP_W'(1) < count_ext) begin
          rd_addr   = ADDR_W'(1);
          state_nxt = ST_DN_LEFT;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = '0;
          wr_data   = mem_rd_r;
          state_nxt = ST_DONE;
        end
      end

      ST_DN_LEFT: begin
        left_nxt  = mem_rd_r;
        rd_addr   = right_ext[ADDR_W-1:0];
        state_nxt = ST_DN_RIGHT;
      end

      ST_DN_RIGHT: begin
        if (key_less(key_r, big_key)) begin
          wr_en   = 1'b1;
          wr_addr = pos_r;
          wr_data = big_key;
          pos_nxt = big_idx;
          if (CMP_W'(next_child) < count_ext) begin
            child_nxt = next_child;
            rd_addr   = next_child[ADDR_W-1:0];
            state_nxt = ST_DN_LEFT;
          end else begin
            state_nxt = ST_PLACE;
          end
        end else begin
          wr_en     = 1'b1;
          wr_addr   = pos_r;
          wr_data   = key_r;
          state_nxt = ST_DONE;
        end
      end

      ST_PLACE: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r;
        wr_data   = key_r;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        // Hold the result until the output register is free.
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: parts the result side from the controller.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      key_out_r    <= top_r;
      status_out_r <= status_r;
    end
  end

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.key_out = key_out_r;
  assign out_ch.status  = status_out_r;

endmodule

// ===== rtl/bmhq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_port_props: port-level checks for the binary max-heap queue
// Watches the item channels over time; bound to binary_max_heap_queue_unit.
// ----------------------------------------------------------------------------
module bmhq_port_props (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [bmhq_pkg::KEY_W-1:0]       key_out,
  input logic [bmhq_pkg::STATUS_W-1:0]    status
);
  import bmhq_pkg::*;

  // A stalled result stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(key_out) && $stable(status))
    else $error("result payload changed while stalled");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == STAT_DONE || status == STAT_EMPTY || status == STAT_FULL))
    else $error("undefined status code");

  // Only a successful remove returns a key; an empty or full result returns zero.
  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != STAT_DONE |-> key_out == '0)
    else $error("nonzero key with empty or full status");

  // One item at a time: the cycle after an accept the input is closed.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

endmodule

bind binary_max_heap_queue_unit bmhq_port_props u_bmhq_port_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .key_out   (out_ch.key_out),
  .status    (out_ch.status)
);
